FILE: hdl/texture_tile_planner_core_macros.svh
// Assertion macros shared by the texture tile planner RTL.
`ifndef TEXTURE_TILE_PLANNER_CORE_MACROS_SVH
`define TEXTURE_TILE_PLANNER_CORE_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define TTP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition leads to a consequence in the next cycle.
`define TTP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/ttp_pkg.sv
// Shared widths, types and helper functions of the texture tile planner.
package ttp_pkg;

	// Field widths.
	localparam int DIM_W = 14;
	localparam int IDX_W = 13;
	localparam int TS_W = 13;
	localparam int SH_W = 4;
	localparam int REM_W = TS_W - 1;

	// Divider organization: two quotient bits per stage.
	localparam int STEPS_PER_STG = 2;
	localparam int DIV_STG = DIM_W / STEPS_PER_STG;

	// Tile size limits as shift amounts, and the reset value.
	localparam int TS_MIN_SH = 2;
	localparam int TS_MAX_SH = 12;
	localparam logic [SH_W-1:0] TILE_RESET_SH = SH_W'(8);

	// Control shared by both axis pipelines.
	typedef struct packed {
		logic ce;
		logic [SH_W-1:0] tshift;
	} pipe_ctl_t;

	// Plan of one axis.
	typedef struct packed {
		logic [DIM_W-1:0] count;
		logic [DIM_W-1:0] start;
		logic [TS_W-1:0] len;
		logic [TS_W-1:0] tex;
		logic t0;
		logic [TS_W-1:0] t1;
	} axis_res_t;

	// Effective tile size as a shift: clamped to the legal range and
	// rounded down to the power of two of the highest set bit.
	function automatic logic [SH_W-1:0] tile_shift(input logic [TS_W-1:0] raw);
		logic [SH_W-1:0] sh;
		sh = SH_W'(TS_MIN_SH);
		for (int j = TS_MIN_SH; j <= TS_MAX_SH; j++) begin
			if (raw[j]) sh = SH_W'(j);
		end
		return sh;
	endfunction

	// Smallest power of two strictly above a nonzero remainder.
	function automatic logic [TS_W-1:0] pow2_above(input logic [REM_W-1:0] r);
		logic [TS_W-1:0] p;
		p = TS_W'(1);
		for (int j = 0; j < REM_W; j++) begin
			if (r[j]) p = TS_W'(1) << (j + 1);
		end
		return p;
	endfunction

endpackage

FILE: hdl/ttp_axis.sv
// Pipelined tile plan of one image axis: divider, clamp, multiply, fields.
module ttp_axis (
	input  logic                              clk,
	input  ttp_pkg::pipe_ctl_t                ctl,
	input  logic [ttp_pkg::DIM_W-1:0]         dim,
	input  logic [ttp_pkg::IDX_W-1:0]         req,
	output ttp_pkg::axis_res_t                res
);

	localparam int NS = ttp_pkg::DIV_STG;

	logic [ttp_pkg::TS_W-1:0]  t_full;
	logic [ttp_pkg::REM_W-1:0] u;

	// Divider stage registers, one entry per stage.
	logic [ttp_pkg::DIM_W-1:0] d_s   [1:NS];
	logic [ttp_pkg::IDX_W-1:0] req_s [1:NS];
	logic [ttp_pkg::REM_W-1:0] rem_s [1:NS];
	logic [ttp_pkg::DIM_W-1:0] quo_s [1:NS];

	// Clamp stage.
	logic [ttp_pkg::DIM_W-1:0] n_nx;
	logic [ttp_pkg::DIM_W-1:0] nm1_nx;
	logic [ttp_pkg::IDX_W-1:0] i_nx;
	logic [ttp_pkg::DIM_W-1:0] n_s8;
	logic [ttp_pkg::IDX_W-1:0] i_s8;
	logic [ttp_pkg::DIM_W-1:0] d_s8;
	logic [ttp_pkg::TS_W-1:0]  edge_s8;
	logic                      first_s8;
	logic                      last_s8;

	// Multiply stage.
	logic [ttp_pkg::DIM_W-1:0] n_s9;
	logic [ttp_pkg::DIM_W-1:0] d_s9;
	logic [ttp_pkg::DIM_W-1:0] prod_s9;
	logic [ttp_pkg::TS_W-1:0]  edge_s9;
	logic                      first_s9;
	logic                      last_s9;

	// Field stage.
	logic [ttp_pkg::DIM_W-1:0] dm;
	logic [ttp_pkg::TS_W-1:0]  len_base;
	ttp_pkg::axis_res_t        res_nx;
	ttp_pkg::axis_res_t        res_s10;

	// Tile edge and useful span per tile.
	assign t_full = ttp_pkg::TS_W'(1) << ctl.tshift;
	assign u = ttp_pkg::REM_W'(t_full - ttp_pkg::TS_W'(2));

	// Restoring division of the dimension by the useful span.
	for (genvar k = 0; k < NS; k++) begin : g_div
		logic [ttp_pkg::DIM_W-1:0] d_in;
		logic [ttp_pkg::IDX_W-1:0] req_in;
		logic [ttp_pkg::REM_W-1:0] rem_in;
		logic [ttp_pkg::DIM_W-1:0] quo_in;
		logic [ttp_pkg::REM_W-1:0] rem_nx;
		logic [ttp_pkg::DIM_W-1:0] quo_nx;
		logic [ttp_pkg::REM_W:0]   trial;

		// The first stage starts from the incoming request.
		if (k == 0) begin : g_in
			assign d_in   = dim;
			assign req_in = req;
			assign rem_in = '0;
			assign quo_in = '0;
		end else begin : g_in
			assign d_in   = d_s[k];
			assign req_in = req_s[k];
			assign rem_in = rem_s[k];
			assign quo_in = quo_s[k];
		end

		always_comb begin
			rem_nx = rem_in;
			quo_nx = quo_in;
			trial  = '0;
			for (int j = 0; j < ttp_pkg::STEPS_PER_STG; j++) begin
				trial = {rem_nx, d_in[ttp_pkg::DIM_W-1-(k*ttp_pkg::STEPS_PER_STG+j)]};
				if (trial >= {1'b0, u}) begin
					rem_nx = ttp_pkg::REM_W'(trial - {1'b0, u});
					quo_nx = {quo_nx[ttp_pkg::DIM_W-2:0], 1'b1};
				end else begin
					rem_nx = trial[ttp_pkg::REM_W-1:0];
					quo_nx = {quo_nx[ttp_pkg::DIM_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.ce) begin
				d_s[k+1]   <= d_in;
				req_s[k+1] <= req_in;
				rem_s[k+1] <= rem_nx;
				quo_s[k+1] <= quo_nx;
			end
		end
	end

	// Tile count and the clamped tile index.
	always_comb begin
		n_nx   = quo_s[NS] + ttp_pkg::DIM_W'(rem_s[NS] != '0);
		nm1_nx = n_nx - ttp_pkg::DIM_W'(1);
		if ({1'b0, req_s[NS]} > nm1_nx) begin
			i_nx = nm1_nx[ttp_pkg::IDX_W-1:0];
		end else begin
			i_nx = req_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ce) begin
			n_s8     <= n_nx;
			i_s8     <= i_nx;
			d_s8     <= d_s[NS];
			edge_s8  <= (rem_s[NS] == '0) ? t_full : ttp_pkg::pow2_above(rem_s[NS]);
			first_s8 <= (i_nx == '0);
			last_s8  <= ({1'b0, i_nx} == nm1_nx);
		end
	end

	// Offset of the tile: index times useful span.
	always_ff @(posedge clk) begin
		if (ctl.ce) begin
			n_s9     <= n_s8;
			d_s9     <= d_s8;
			prod_s9  <= {1'b0, i_s8} * {2'b00, u};
			edge_s9  <= edge_s8;
			first_s9 <= first_s8;
			last_s9  <= last_s8;
		end
	end

	// Source rectangle, texture size and texel span.
	always_comb begin
		dm = d_s9 - prod_s9;
		len_base = last_s9 ? dm[ttp_pkg::TS_W-1:0] : {1'b0, u};
		res_nx.count = n_s9;
		res_nx.start = first_s9 ? '0 : prod_s9 - ttp_pkg::DIM_W'(1);
		res_nx.len = len_base + ttp_pkg::TS_W'(2) - ttp_pkg::TS_W'(first_s9)
			- ttp_pkg::TS_W'(last_s9);
		res_nx.tex = last_s9 ? edge_s9 : t_full;
		res_nx.t0 = !first_s9;
		if (first_s9 && !last_s9) begin
			res_nx.t1 = {1'b0, u};
		end else if (!last_s9) begin
			res_nx.t1 = t_full - ttp_pkg::TS_W'(1);
		end else begin
			res_nx.t1 = dm[ttp_pkg::TS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ce) begin
			res_s10 <= res_nx;
		end
	end

	assign res = res_s10;

endmodule

FILE: hdl/texture_tile_planner_core.sv
// Texture tile planner top level: stream ports, tile size register, output buffer.
//
// Usage: a request on the s_axis channel gives an image width and height and a
// tile column and row; one result per request leaves on m_axis, in order. The
// result holds the tile counts, the source rectangle including its one-texel
// border, the texture size and the used texel span for each axis. The tile size
// register is written through cfg_we/cfg_wdata; the user must do so only while
// no request is in flight, which the block does not enforce. The pipeline has
// seven divider stages of two quotient bits each, a clamp stage, a multiply
// stage, a field stage and the output register. Throughput is one request per
// cycle unless stalled. A stalled receiver holds the output register; a skid
// register takes one more result, and only then does s_axis_tready drop, so
// nothing is lost or repeated. Reset clears all valid bits and loads a tile size
// of 256. A zero width or height gives a result with every field zero.
`include "texture_tile_planner_core_macros.svh"

module texture_tile_planner_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [12:0]  cfg_wdata,      // tile_size
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [55:0]  s_axis_tdata,   // img_width, img_height, tile_col, tile_row, pad
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [135:0] m_axis_tdata    // tiles_across, tiles_down, src_x, src_y,
	                                     // src_w, src_h, tex_w, tex_h, texel_x0,
	                                     // texel_x1, texel_y0, texel_y1
);

	localparam int LAT = ttp_pkg::DIV_STG + 3;

	logic [ttp_pkg::SH_W-1:0] tshift_q;
	ttp_pkg::pipe_ctl_t       ctl;
	logic [LAT:1]             vld_s;
	logic [LAT:1]             zero_s;
	ttp_pkg::axis_res_t       res_x;
	ttp_pkg::axis_res_t       res_y;
	logic [135:0]             pipe_data;
	logic [135:0]             out_q;
	logic                     out_vld_q;
	logic [135:0]             skid_q;
	logic                     skid_vld_q;

	// Tile size register, kept as a clamped shift amount.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tshift_q <= ttp_pkg::TILE_RESET_SH;
		end else if (cfg_we) begin
			tshift_q <= ttp_pkg::tile_shift(cfg_wdata);
		end
	end

	// The pipeline advances while the skid register is free.
	assign ctl.ce     = !skid_vld_q;
	assign ctl.tshift = tshift_q;
	assign s_axis_tready = ctl.ce;

	// Valid and zero-size flags travel beside the axis pipelines.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ctl.ce) begin
			vld_s <= {vld_s[LAT-1:1], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ce) begin
			zero_s <= {zero_s[LAT-1:1],
				(s_axis_tdata[13:0] == '0) || (s_axis_tdata[27:14] == '0)};
		end
	end

	// One pipeline per axis.
	ttp_axis u_axis_x (
		.clk (clk),
		.ctl (ctl),
		.dim (s_axis_tdata[13:0]),
		.req (s_axis_tdata[40:28]),
		.res (res_x)
	);

	ttp_axis u_axis_y (
		.clk (clk),
		.ctl (ctl),
		.dim (s_axis_tdata[27:14]),
		.req (s_axis_tdata[53:41]),
		.res (res_y)
	);

	// Pack the result, forcing zeros for an empty image.
	always_comb begin
		if (zero_s[LAT]) begin
			pipe_data = '0;
		end else begin
			pipe_data = {res_y.t1, res_y.t0, res_x.t1, res_x.t0, res_y.tex, res_x.tex,
				res_y.len, res_x.len, res_y.start, res_x.start, res_y.count, res_x.count};
		end
	end

	// Output register with a skid register behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || m_axis_tready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= vld_s[LAT];
			end
		end else if (vld_s[LAT] && ctl.ce) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || m_axis_tready) begin
			out_q <= skid_vld_q ? skid_q : pipe_data;
		end else if (vld_s[LAT] && ctl.ce) begin
			skid_q <= pipe_data;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

	// The skid register only fills behind a full output register.
	`TTP_ASSERT(a_skid_behind_out, !skid_vld_q || out_vld_q, "skid full with output empty")

	// A result arriving at a stalled output is parked in the skid register.
	`TTP_ASSERT_NEXT(a_skid_catch, out_vld_q && !m_axis_tready && vld_s[LAT] && !skid_vld_q, skid_vld_q, "result dropped at stalled output")

	// A parked result does not change while the output stays stalled.
	`TTP_ASSERT_NEXT(a_skid_hold, skid_vld_q && !m_axis_tready, skid_vld_q && $stable(skid_q), "parked result changed")

	// A zero tile count only comes from an empty image, whose fields are all zero.
	`TTP_ASSERT(a_zero_result, !(m_axis_tvalid && m_axis_tdata[13:0] == '0) || m_axis_tdata == '0, "zero count with nonzero fields")

endmodule
